@@ rtl/core/rbf_pkg.sv @@
// Shared constants and types for the byte ring FIFO with peek.
package rbf_pkg;

  localparam int DEPTH = 256;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = ((PTR_W > 8) ? PTR_W : 8) + 1;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_FRAME_BEGIN = 3'd1;
  localparam logic [2:0] MODE_FRAME_BYTE = 3'd2;
  localparam logic [2:0] MODE_POP = 3'd3;
  localparam logic [2:0] MODE_PEEK = 3'd4;
  localparam logic [2:0] MODE_DROP = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic [7:0] length;
    logic [7:0] distance;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       vld;
    logic       ok;
    logic       rd_en;
    logic [7:0] read_count;
    logic [7:0] write_count;
  } res_t;

endpackage

@@ rtl/core/rbf_mem.sv @@
// Byte store with one write port and one registered read port.
module rbf_mem
  import rbf_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/rbf_ctrl.sv @@
// Pointer, frame and count logic with the registered result flags.
module rbf_ctrl
  import rbf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_vld,
  input  item_t    item,
  output mem_req_t mem_req,
  output res_t     res
);

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [7:0]       frem_r, frem_nxt;
  logic [7:0]       foff_r, foff_nxt;
  res_t             res_r, res_nxt;

  function automatic logic [PTR_W-1:0] wrap(input logic [CMP_W-1:0] s);
    logic [CMP_W-1:0] t;
    t = (s >= CMP_W'(DEPTH)) ? (s - CMP_W'(DEPTH)) : s;
    return t[PTR_W-1:0];
  endfunction

  function automatic logic [CMP_W-1:0] fill(input logic [PTR_W-1:0] w,
                                            input logic [PTR_W-1:0] r);
    logic [CMP_W-1:0] d;
    d = CMP_W'(w) - CMP_W'(r);
    if (w < r) begin
      d = d + CMP_W'(DEPTH);
    end
    return d;
  endfunction

  function automatic logic [7:0] sat8(input logic [CMP_W-1:0] v);
    return (v > CMP_W'(255)) ? 8'd255 : v[7:0];
  endfunction

  logic [CMP_W-1:0] used;
  logic [CMP_W-1:0] room;
  logic [CMP_W-1:0] used_nxt;
  logic [CMP_W-1:0] len_w;
  logic [CMP_W-1:0] dist_w;

  always_comb begin
    used     = fill(wp_r, rp_r);
    room     = CMP_W'(DEPTH - 1) - used;
    len_w    = CMP_W'(item.length);
    dist_w   = CMP_W'(item.distance);
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    frem_nxt = frem_r;
    foff_nxt = foff_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = wrap(CMP_W'(wp_r) + CMP_W'(foff_r));
    mem_req.wdata = item.data_byte;
    mem_req.raddr = rp_r;
    res_nxt       = '0;
    res_nxt.vld   = item_vld;

    if (item_vld) begin
      case (item.mode)
        MODE_CLEAR: begin
          wp_nxt      = '0;
          rp_nxt      = '0;
          frem_nxt    = '0;
          foff_nxt    = '0;
          res_nxt.ok  = 1'b1;
        end
        MODE_FRAME_BEGIN: begin
          frem_nxt = '0;
          foff_nxt = '0;
          if (item.length != 8'd0 && len_w <= room) begin
            frem_nxt   = item.length;
            res_nxt.ok = 1'b1;
          end
        end
        MODE_FRAME_BYTE: begin
          if (frem_r != 8'd0) begin
            mem_req.we = 1'b1;
            foff_nxt   = foff_r + 8'd1;
            frem_nxt   = frem_r - 8'd1;
            if (frem_r == 8'd1) begin
              wp_nxt   = wrap(CMP_W'(wp_r) + CMP_W'(foff_r) + CMP_W'(1));
              foff_nxt = '0;
            end
            res_nxt.ok = 1'b1;
          end
        end
        MODE_POP: begin
          if (used != '0) begin
            rp_nxt        = wrap(CMP_W'(rp_r) + CMP_W'(1));
            res_nxt.ok    = 1'b1;
            res_nxt.rd_en = 1'b1;
          end
        end
        MODE_PEEK: begin
          mem_req.raddr = wrap(CMP_W'(rp_r) + dist_w);
          if (dist_w < used) begin
            res_nxt.ok    = 1'b1;
            res_nxt.rd_en = 1'b1;
          end
        end
        MODE_DROP: begin
          if (item.length != 8'd0 && len_w <= used) begin
            rp_nxt     = wrap(CMP_W'(rp_r) + len_w);
            res_nxt.ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    used_nxt            = fill(wp_nxt, rp_nxt);
    res_nxt.read_count  = sat8(used_nxt);
    res_nxt.write_count = sat8(CMP_W'(DEPTH - 1) - used_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      frem_r <= '0;
      foff_r <= '0;
      res_r  <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      frem_r <= frem_nxt;
      foff_r <= foff_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/core/byte_ring_fifo_with_peek.sv @@
// Top level of the byte ring FIFO with frame admission, pop, peek and drop.
//
// One command word is taken on every clock at which start is high; busy is
// always low. The result word appears on the out_ ports with out_strobe high
// for one cycle, after the command passes the command register and then the
// pointer logic with its result register and the registered read port of the
// byte store. Results cannot be held off, and the next result may follow in
// the very next cycle.
module byte_ring_fifo_with_peek
  import rbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_length,
  input  logic [7:0] in_distance,
  output logic       out_strobe,
  output logic       out_ok,
  output logic [7:0] out_read_data,
  output logic [7:0] out_read_count,
  output logic [7:0] out_write_count
);

  item_t      item_r;
  logic       item_vld_r;
  mem_req_t   mem_req;
  res_t       res;
  logic [7:0] rdata;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r.mode      <= in_mode;
      item_r.data_byte <= in_data_byte;
      item_r.length    <= in_length;
      item_r.distance  <= in_distance;
    end
  end

  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld_r),
    .item     (item_r),
    .mem_req  (mem_req),
    .res      (res)
  );

  rbf_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign out_strobe      = res.vld;
  assign out_ok          = res.ok;
  assign out_read_data   = res.rd_en ? rdata : 8'd0;
  assign out_read_count  = res.read_count;
  assign out_write_count = res.write_count;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("result missing two cycles after command");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without a command");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ok) |-> (out_read_data == 8'd0))
    else $error("rejected command returned data");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((DEPTH > 256) ||
      ((9'(out_read_count) + 9'(out_write_count)) == 9'(DEPTH - 1))))
    else $error("read and write counts disagree");

endmodule

@@ dv/byte_ring_fifo_with_peek_checker.sv @@
// Checker that predicts and compares every result word of the byte ring FIFO.
module byte_ring_fifo_with_peek_checker
  import rbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_length,
  input  logic [7:0] in_distance,
  input  logic       out_strobe,
  input  logic       out_ok,
  input  logic [7:0] out_read_data,
  input  logic [7:0] out_read_count,
  input  logic [7:0] out_write_count,
  output int         mismatch_count,
  output int         words_waiting,
  output int         words_checked,
  output int         full_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       ok;
    logic [7:0] read_data;
    logic [7:0] read_count;
    logic [7:0] write_count;
  } answer_t;

  logic [7:0] byte_mem [DEPTH];
  int         wr_ptr;
  int         rd_ptr;
  int         frame_left;
  int         frame_off;
  answer_t    expected_answers [$];

  function automatic int fill_level();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic logic [7:0] clip8(int v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic answer_t apply_command(logic [2:0] m, logic [7:0] d, logic [7:0] l,
                                            logic [7:0] s);
    answer_t a;
    int      used;
    int      room;
    used = fill_level();
    room = DEPTH - 1 - used;
    a = '0;
    case (m)
      MODE_CLEAR: begin
        wr_ptr = 0;
        rd_ptr = 0;
        frame_left = 0;
        frame_off = 0;
        a.ok = 1'b1;
      end
      MODE_FRAME_BEGIN: begin
        frame_left = 0;
        frame_off = 0;
        if (int'(l) > 0 && int'(l) <= room) begin
          frame_left = int'(l);
          a.ok = 1'b1;
        end
      end
      MODE_FRAME_BYTE: begin
        if (frame_left > 0) begin
          byte_mem[(wr_ptr + frame_off) % DEPTH] = d;
          frame_off++;
          frame_left--;
          if (frame_left == 0) begin
            wr_ptr = (wr_ptr + frame_off) % DEPTH;
            frame_off = 0;
          end
          a.ok = 1'b1;
        end
      end
      MODE_POP: begin
        if (used > 0) begin
          a.read_data = byte_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          a.ok = 1'b1;
        end
      end
      MODE_PEEK: begin
        if (int'(s) < used) begin
          a.read_data = byte_mem[(rd_ptr + int'(s)) % DEPTH];
          a.ok = 1'b1;
        end
      end
      MODE_DROP: begin
        if (int'(l) > 0 && int'(l) <= used) begin
          rd_ptr = (rd_ptr + int'(l)) % DEPTH;
          a.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    used = fill_level();
    a.read_count = clip8(used);
    a.write_count = clip8(DEPTH - 1 - used);
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    if (mismatch_count < 40) begin
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst_n) begin
      wr_ptr = 0;
      rd_ptr = 0;
      frame_left = 0;
      frame_off = 0;
      expected_answers.delete();
    end else begin
      if (out_strobe) begin
        got = '{out_ok, out_read_data, out_read_count, out_write_count};
        if (expected_answers.size() == 0) begin
          report_mismatch("result word with nothing expected", 8'd0, 8'd0);
        end else begin
          want = expected_answers.pop_front();
          words_checked <= words_checked + 1;
          if (got.ok !== want.ok) report_mismatch("ok", 8'(want.ok), 8'(got.ok));
          if (got.read_data !== want.read_data) begin
            report_mismatch("read_data", want.read_data, got.read_data);
          end
          if (got.read_count !== want.read_count) begin
            report_mismatch("read_count", want.read_count, got.read_count);
          end
          if (got.write_count !== want.write_count) begin
            report_mismatch("write_count", want.write_count, got.write_count);
          end
        end
      end
      if (start && !busy) begin
        want = apply_command(in_mode, in_data_byte, in_length, in_distance);
        expected_answers.push_back(want);
        if (want.write_count == 8'd0) full_results <= full_results + 1;
      end
    end
    words_waiting <= expected_answers.size();
  end

endmodule

@@ dv/byte_ring_fifo_with_peek_test.sv @@
// Testbench top for the byte ring FIFO: clock, reset, command stimulus and verdict.
module byte_ring_fifo_with_peek_test;
  import rbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int         RANDOM_WORDS = 1400;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_mode;
  logic [7:0] in_data_byte;
  logic [7:0] in_length;
  logic [7:0] in_distance;
  logic       out_strobe;
  logic       out_ok;
  logic [7:0] out_read_data;
  logic [7:0] out_read_count;
  logic [7:0] out_write_count;

  int mismatch_count;
  int words_waiting;
  int words_checked;
  int full_results;
  int words_sent;
  int level;
  bit burst;

  byte_ring_fifo_with_peek i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .in_length      (in_length),
    .in_distance    (in_distance),
    .out_strobe     (out_strobe),
    .out_ok         (out_ok),
    .out_read_data  (out_read_data),
    .out_read_count (out_read_count),
    .out_write_count(out_write_count)
  );

  byte_ring_fifo_with_peek_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .in_length      (in_length),
    .in_distance    (in_distance),
    .out_strobe     (out_strobe),
    .out_ok         (out_ok),
    .out_read_data  (out_read_data),
    .out_read_count (out_read_count),
    .out_write_count(out_write_count),
    .mismatch_count (mismatch_count),
    .words_waiting  (words_waiting),
    .words_checked  (words_checked),
    .full_results   (full_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still expected.", words_waiting);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_word(input logic [2:0] m, input logic [7:0] d, input logic [7:0] l,
                           input logic [7:0] s, input bit counted);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_data_byte <= d;
    in_length <= l;
    in_distance <= s;
    do @(posedge clk); while (busy);
    if (counted) words_sent++;
  endtask

  initial begin
    int  r;
    int  k;
    int  i;
    int  n;
    int  len;
    int  cut;
    int  room;
    bit  filling;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_CLEAR;
    in_data_byte <= 8'd0;
    in_length <= 8'd0;
    in_distance <= 8'd0;
    burst = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_word(MODE_POP, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_PEEK, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_DROP, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_DROP, 8'h00, 8'hFF, 8'h00, 1);
    send_word(MODE_FRAME_BYTE, 8'hFF, 8'h00, 8'h00, 1);
    send_word(MODE_SPARE_6, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 1);
    send_word(MODE_FRAME_BEGIN, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_FRAME_BEGIN, 8'h00, 8'hFF, 8'h00, 1);
    send_word(MODE_FRAME_BEGIN, 8'h00, 8'h03, 8'h00, 1);
    send_word(MODE_FRAME_BYTE, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_FRAME_BYTE, 8'hFF, 8'h00, 8'h00, 1);
    send_word(MODE_FRAME_BYTE, 8'h5A, 8'h00, 8'h00, 1);
    send_word(MODE_PEEK, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_PEEK, 8'h00, 8'h00, 8'h02, 1);
    send_word(MODE_PEEK, 8'h00, 8'h00, 8'h03, 1);
    send_word(MODE_PEEK, 8'h00, 8'h00, 8'hFF, 1);
    send_word(MODE_DROP, 8'h00, 8'h04, 8'h00, 1);
    send_word(MODE_DROP, 8'h00, 8'h02, 8'h00, 1);
    send_word(MODE_POP, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_POP, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_FRAME_BEGIN, 8'h00, 8'h02, 8'h00, 1);
    send_word(MODE_FRAME_BYTE, 8'h81, 8'h00, 8'h00, 1);
    send_word(MODE_CLEAR, 8'h00, 8'h00, 8'h00, 1);
    send_word(MODE_POP, 8'h00, 8'h00, 8'h00, 1);
    level = 0;
    filling = 1'b1;
    burst = 1'b0;

    while (words_sent < RANDOM_WORDS) begin
      room = DEPTH - 1 - level;
      if (level > 240) filling = 1'b0;
      if (level < 6) filling = 1'b1;
      if ($urandom_range(0, 63) == 0) burst = !burst;
      r = $urandom_range(0, 99);
      if (r < (filling ? 65 : 12)) begin
        r = $urandom_range(0, 99);
        if (room == 0 || r < 8) begin
          len = (room == DEPTH - 1 || $urandom_range(0, 1)) ? 0 : $urandom_range(room + 1, 255);
          send_word(MODE_FRAME_BEGIN, 8'($urandom), 8'(len), 8'($urandom), 1);
        end else begin
          len = (r < 20) ? room : $urandom_range(1, (room < 12) ? room : 12);
          cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
          send_word(MODE_FRAME_BEGIN, 8'($urandom), 8'(len), 8'($urandom), 1);
          for (i = 0; i < cut; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              if ($urandom_range(0, 1)) begin
                send_word(MODE_POP, 8'($urandom), 8'($urandom), 8'($urandom), 1);
                if (level > 0) level--;
              end else begin
                send_word(MODE_PEEK, 8'($urandom), 8'($urandom),
                          8'($urandom_range(0, level)), 1);
              end
            end
            send_word(MODE_FRAME_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 1);
          end
          if (cut == len) begin
            level += len;
          end else if ($urandom_range(0, 1)) begin
            send_word(MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1);
            level = 0;
          end else begin
            send_word(MODE_FRAME_BEGIN, 8'($urandom), 8'd0, 8'($urandom), 1);
          end
        end
      end else begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 4);
        if (r < 35) begin
          send_word(MODE_POP, 8'($urandom), 8'($urandom), 8'($urandom), 1);
          if (level > 0) level--;
        end else if (r < 55) begin
          if (k == 0) n = $urandom_range(0, 255);
          else if (k == 1) n = level;
          else n = $urandom_range(0, (level > 0) ? level - 1 : 0);
          send_word(MODE_PEEK, 8'($urandom), 8'($urandom), 8'(n), 1);
        end else if (r < 75) begin
          if (k == 0) len = 0;
          else if (k == 1) len = level;
          else if (k == 2) len = (level < 255) ? level + 1 : $urandom_range(0, 255);
          else len = $urandom_range(1, (level > 16) ? level / 2 : 8);
          send_word(MODE_DROP, 8'($urandom), 8'(len), 8'($urandom), 1);
          if (len > 0 && len <= level) level -= len;
        end else if (r < 78) begin
          send_word(MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1);
          level = 0;
        end else if (r < 86) begin
          len = (room == DEPTH - 1 || k < 2) ? 0 : $urandom_range(room + 1, 255);
          send_word(MODE_FRAME_BEGIN, 8'($urandom), 8'(len), 8'($urandom), 1);
        end else if (r < 93) begin
          send_word(MODE_FRAME_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 1);
        end else begin
          send_word(k[0] ? MODE_SPARE_6 : MODE_SPARE_7, 8'($urandom), 8'($urandom),
                    8'($urandom), 1);
        end
      end
    end
    start <= 1'b0;

    for (n = 0; n < 1000 && words_waiting != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d command words; %0d result words were checked.",
             words_sent, words_checked);
    $display("The FIFO stood full in %0d of the results.", full_results);
    if (words_waiting != 0) begin
      $display("%0d expected result words never arrived.", words_waiting);
    end
    if (mismatch_count == 0 && words_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ byte_ring_fifo_with_peek.f @@
rtl/core/rbf_pkg.sv
rtl/core/rbf_mem.sv
rtl/core/rbf_ctrl.sv
rtl/core/byte_ring_fifo_with_peek.sv
dv/byte_ring_fifo_with_peek_checker.sv
dv/byte_ring_fifo_with_peek_test.sv
